>>> sv/tpa_pkg.sv
// shared widths, types and arctangent table for the three point angle core
package tpa_pkg;

   localparam int COORD_BITS    = 16;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int SUM_BITS      = PROD_BITS + 1;
   localparam int VEC_BITS      = SUM_BITS + 3;
   localparam int ACC_FRAC      = 24;
   localparam int ACC_BITS      = 34;
   localparam int FRAC_BITS     = 8;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_ITERS  = 16;
   localparam int TABLE_LEN     = 24;
   localparam int HALF_TURN_DEG = 180;
   localparam int RIGHT_DEG     = 90;
   localparam int ROUND_SHIFT   = ACC_FRAC - FRAC_BITS;
   localparam int REQ_BITS      = 6 * COORD_BITS;

   typedef logic signed [DIFF_BITS-1:0] diff_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [SUM_BITS-1:0]  sum_type;
   typedef logic signed [VEC_BITS-1:0]  vec_type;
   typedef logic signed [ACC_BITS-1:0]  acc_type;

   typedef struct packed {
      vec_type x;
      vec_type y;
      acc_type z;
      logic    degen;
   } cordic_item_type;

   localparam acc_type HALF_TURN_Q  = acc_type'(longint'(HALF_TURN_DEG) <<< ACC_FRAC);
   localparam acc_type RIGHT_Q      = acc_type'(longint'(RIGHT_DEG) <<< ACC_FRAC);
   localparam acc_type ROUND_HALF   = acc_type'(longint'(1) <<< (ROUND_SHIFT - 1));
   localparam logic [ANGLE_BITS-1:0] ANGLE_MAX =
      ANGLE_BITS'(HALF_TURN_DEG << FRAC_BITS);

   // atan(2^-i) in degrees, 24 fraction bits
   localparam logic [31:0] ATAN_DEG_Q24 [TABLE_LEN] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
      32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
      32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
      32'd234684,    32'd117342,    32'd58671,     32'd29335,
      32'd14668,     32'd7334,      32'd3667,      32'd1833,
      32'd917,       32'd458,       32'd229,       32'd115
   };

endpackage

>>> sv/tpa_cordic.sv
// pipelined cordic vectoring, one iteration per register stage
module tpa_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  tpa_pkg::cordic_item_type in_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output tpa_pkg::cordic_item_type out_item
);

   localparam int LAST = tpa_pkg::CORDIC_ITERS - 1;

   tpa_pkg::cordic_item_type item_ff  [tpa_pkg::CORDIC_ITERS];
   logic                     valid_ff [tpa_pkg::CORDIC_ITERS];
   logic                     rdy      [tpa_pkg::CORDIC_ITERS];

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      rdy[LAST] = !valid_ff[LAST] || out_ready;
      for (int s = LAST - 1; s >= 0; s--) begin
         rdy[s] = !valid_ff[s] || rdy[s+1];
      end
   end

   for (genvar s = 0; s < tpa_pkg::CORDIC_ITERS; s++) begin : g_iter
      tpa_pkg::cordic_item_type cur;
      tpa_pkg::cordic_item_type item_in;
      logic                     valid_in;
      tpa_pkg::vec_type         xs;
      tpa_pkg::vec_type         ys;
      tpa_pkg::acc_type         step;

      if (s == 0) begin : g_first
         assign cur      = in_item;
         assign valid_in = in_valid;
      end else begin : g_next
         assign cur      = item_ff[s-1];
         assign valid_in = valid_ff[s-1];
      end

      assign xs   = cur.x >>> s;
      assign ys   = cur.y >>> s;
      assign step = tpa_pkg::acc_type'(tpa_pkg::ATAN_DEG_Q24[s]);

      always_comb begin
         item_in.degen = cur.degen;
         if (!cur.y[tpa_pkg::VEC_BITS-1]) begin
            item_in.x = cur.x + ys;
            item_in.y = cur.y - xs;
            item_in.z = cur.z + step;
         end else begin
            item_in.x = cur.x - ys;
            item_in.y = cur.y + xs;
            item_in.z = cur.z - step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            valid_ff[s] <= valid_in;
         end
         if (rdy[s]) begin
            item_ff[s] <= item_in;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[LAST];
   assign out_item  = item_ff[LAST];

endmodule

>>> sv/three_point_angle_core.sv
// top level: arm vectors, dot and cross products, cordic angle, rounding
// throughput: one request per cycle while rsp_tready keeps the output stage moving;
// 3 front stages, 16 cordic stages, 1 output stage
// each stage advances when empty or when the stage after it advances
// reset: synchronous, clears all valid bits; the pipeline comes up empty
module three_point_angle_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // arm_a_x, arm_a_y, vertex_x, vertex_y, arm_b_x, arm_b_y
   input  logic [tpa_pkg::REQ_BITS-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // angle_degrees
   output logic [tpa_pkg::ANGLE_BITS-1:0] rsp_tdata,
   // degenerate
   output logic [0:0]                   rsp_tuser
);

   localparam int CB = tpa_pkg::COORD_BITS;
   localparam int RQ_BITS = tpa_pkg::ACC_BITS + 1 - tpa_pkg::ROUND_SHIFT;

   // stage 1: arm vectors
   tpa_pkg::diff_type ax_in, ay_in, bx_in, by_in;
   tpa_pkg::diff_type ax_ff, ay_ff, bx_ff, by_ff;
   logic              degen1_in, degen1_ff, v1_ff, r1;

   // stage 2: products
   tpa_pkg::prod_type axbx_ff, ayby_ff, axby_ff, bxay_ff;
   logic              degen2_ff, v2_ff, r2;

   // stage 3: dot, cross, pre-rotation
   tpa_pkg::sum_type         dot, crs, crs_abs;
   tpa_pkg::cordic_item_type item3_in, item3_ff;
   logic                     v3_ff, r3;

   // cordic and output
   logic                     cor_ready, cor_valid;
   tpa_pkg::cordic_item_type cor_item;
   tpa_pkg::acc_type         z_clamp;
   logic [tpa_pkg::ACC_BITS:0] rnd;
   logic [RQ_BITS-1:0]         rq;
   logic [tpa_pkg::ANGLE_BITS-1:0] angle_in, angle_ff;
   logic                     degen_out_ff, rsp_valid_ff, r_out;

   assign r_out      = !rsp_valid_ff || rsp_tready;
   assign r3         = !v3_ff || cor_ready;
   assign r2         = !v2_ff || r3;
   assign r1         = !v1_ff || r2;
   assign req_tready = r1;

   always_comb begin
      ax_in = tpa_pkg::DIFF_BITS'($signed(req_tdata[CB-1:0]))
            - tpa_pkg::DIFF_BITS'($signed(req_tdata[3*CB-1:2*CB]));
      ay_in = tpa_pkg::DIFF_BITS'($signed(req_tdata[2*CB-1:CB]))
            - tpa_pkg::DIFF_BITS'($signed(req_tdata[4*CB-1:3*CB]));
      bx_in = tpa_pkg::DIFF_BITS'($signed(req_tdata[5*CB-1:4*CB]))
            - tpa_pkg::DIFF_BITS'($signed(req_tdata[3*CB-1:2*CB]));
      by_in = tpa_pkg::DIFF_BITS'($signed(req_tdata[6*CB-1:5*CB]))
            - tpa_pkg::DIFF_BITS'($signed(req_tdata[4*CB-1:3*CB]));
      degen1_in = (ax_in == '0 && ay_in == '0) || (bx_in == '0 && by_in == '0);
   end

   always_comb begin
      dot     = tpa_pkg::sum_type'(axbx_ff) + tpa_pkg::sum_type'(ayby_ff);
      crs     = tpa_pkg::sum_type'(axby_ff) - tpa_pkg::sum_type'(bxay_ff);
      crs_abs = crs[tpa_pkg::SUM_BITS-1] ? -crs : crs;
      item3_in.degen = degen2_ff;
      if (dot[tpa_pkg::SUM_BITS-1]) begin
         item3_in.x = tpa_pkg::vec_type'(crs_abs);
         item3_in.y = -tpa_pkg::vec_type'(dot);
         item3_in.z = tpa_pkg::RIGHT_Q;
      end else begin
         item3_in.x = tpa_pkg::vec_type'(dot);
         item3_in.y = tpa_pkg::vec_type'(crs_abs);
         item3_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= req_tvalid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
      end
      if (r1) begin
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         bx_ff     <= bx_in;
         by_ff     <= by_in;
         degen1_ff <= degen1_in;
      end
      if (r2) begin
         axbx_ff   <= ax_ff * bx_ff;
         ayby_ff   <= ay_ff * by_ff;
         axby_ff   <= ax_ff * by_ff;
         bxay_ff   <= bx_ff * ay_ff;
         degen2_ff <= degen1_ff;
      end
      if (r3) begin
         item3_ff <= item3_in;
      end
   end

   tpa_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_ready  (cor_ready),
      .in_item   (item3_ff),
      .out_valid (cor_valid),
      .out_ready (r_out),
      .out_item  (cor_item)
   );

   // clamp to zero and the half turn, round to the output step, zero degenerate results
   always_comb begin
      if (cor_item.z[tpa_pkg::ACC_BITS-1]) begin
         z_clamp = '0;
      end else if (cor_item.z > tpa_pkg::HALF_TURN_Q) begin
         z_clamp = tpa_pkg::HALF_TURN_Q;
      end else begin
         z_clamp = cor_item.z;
      end
      rnd = {1'b0, z_clamp} + {1'b0, tpa_pkg::ROUND_HALF};
      rq  = rnd[tpa_pkg::ACC_BITS:tpa_pkg::ROUND_SHIFT];
      if (cor_item.degen) begin
         angle_in = '0;
      end else if (rq > RQ_BITS'(tpa_pkg::ANGLE_MAX)) begin
         angle_in = tpa_pkg::ANGLE_MAX;
      end else begin
         angle_in = rq[tpa_pkg::ANGLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (r_out) begin
         rsp_valid_ff <= cor_valid;
      end
      if (r_out) begin
         angle_ff     <= angle_in;
         degen_out_ff <= cor_item.degen;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = angle_ff;
   assign rsp_tuser[0] = degen_out_ff;

`ifndef SYNTHESIS
   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("degenerate result with nonzero angle");

   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= tpa_pkg::ANGLE_MAX)
      else $error("angle above half turn");

   a_stall_source : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without a blocked result");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !v1_ff && !v3_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule
